// File: rtl/core/rff_pkg.sv
// shared constants and types for the received id replay filter
// no dependencies
`default_nettype none
package rff_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int GRP_SZ = 16;
  localparam int NUM_GRP = (TABLE_DEPTH + GRP_SZ - 1) / GRP_SZ;

  localparam logic [1:0] MODE_REG = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_OLD = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [1:0] ST_NEED_ACK = 2'd1;
  localparam logic [1:0] ST_NO_ACK = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_ACT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic compare;
    logic reduce;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/core/rff_datapath.sv
// sorted shift-cell id table with compare flags, or-reduction and result regs
// depends on rff_pkg
`default_nettype none
module rff_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rff_pkg::cmd_t         cmd,
  output rff_pkg::stat_t             stat,
  input  wire logic [1:0]            mode,
  input  wire logic [63:0]           msg_id,
  input  wire logic                  need_ack,
  output logic [1:0]                 status,
  output logic [63:0]                oldest_id,
  output logic [63:0]                newest_id,
  output logic [8:0]                 entry_count
);
  import rff_pkg::*;

  logic [63:0] ids [TABLE_DEPTH];
  logic        acks [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_r, eq_r, eqack_r, ge_r;
  logic [NUM_GRP-1:0] g_eq, g_eqack, g_ge;
  logic [NUM_GRP-1:0] g_eq_next, g_eqack_next, g_ge_next;
  logic [CNT_W-1:0] count;
  logic [63:0] newest;
  logic [1:0]  mode_r;
  logic [63:0] id_r;
  logic        ack_r;
  logic [1:0]  res;
  logic [1:0]  res_next;
  logic        full, dup, hit_ack, ge_any, do_ins;
  logic [TABLE_DEPTH-1:0] valid;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      valid[i] = count > CNT_W'(i);
    end
  end

  // group-level or of the per-cell flags
  always_comb begin
    g_eq_next = '0;
    g_eqack_next = '0;
    g_ge_next = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      for (int k = 0; k < GRP_SZ; k++) begin
        if (g * GRP_SZ + k < TABLE_DEPTH) begin
          g_eq_next[g] = g_eq_next[g] | eq_r[g * GRP_SZ + k];
          g_eqack_next[g] = g_eqack_next[g] | eqack_r[g * GRP_SZ + k];
          g_ge_next[g] = g_ge_next[g] | ge_r[g * GRP_SZ + k];
        end
      end
    end
  end

  always_comb begin
    res_next = ST_OK;
    if (mode_r == MODE_REG) begin
      if (dup) res_next = ST_DUP;
      else if (full && !lt_r[0]) res_next = ST_OLD;
    end else if (mode_r == MODE_LOOKUP) begin
      if (!dup) res_next = ST_NOT_FOUND;
      else if (hit_ack) res_next = ST_NEED_ACK;
      else res_next = ST_NO_ACK;
    end
  end

  assign full = count == CNT_W'(TABLE_DEPTH);
  assign dup = |g_eq;
  assign hit_ack = |g_eqack;
  assign ge_any = |g_ge;
  assign do_ins = cmd.apply && mode_r == MODE_REG && !dup && !(full && !lt_r[0]);
  assign stat.is_clear = mode_r == MODE_CLEAR;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= mode;
      id_r <= msg_id;
      ack_r <= need_ack;
    end
    if (cmd.compare) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        lt_r[i] <= valid[i] && ids[i] < id_r;
        eq_r[i] <= valid[i] && ids[i] == id_r;
        eqack_r[i] <= valid[i] && ids[i] == id_r && acks[i];
        ge_r[i] <= valid[i] && !(ids[i] < id_r);
      end
    end
    if (cmd.reduce) begin
      g_eq <= g_eq_next;
      g_eqack <= g_eqack_next;
      g_ge <= g_ge_next;
    end
    if (do_ins) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (full) begin
          if (i < TABLE_DEPTH - 1 && lt_r[(i + 1) % TABLE_DEPTH]) begin
            ids[i] <= ids[(i + 1) % TABLE_DEPTH];
            acks[i] <= acks[(i + 1) % TABLE_DEPTH];
          end else if (lt_r[i]) begin
            ids[i] <= id_r;
            acks[i] <= ack_r;
          end
        end else if (!lt_r[i]) begin
          if (i == 0 || lt_r[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]) begin
            ids[i] <= id_r;
            acks[i] <= ack_r;
          end else begin
            ids[i] <= ids[(i + TABLE_DEPTH - 1) % TABLE_DEPTH];
            acks[i] <= acks[(i + TABLE_DEPTH - 1) % TABLE_DEPTH];
          end
        end
      end
      if (!ge_any) newest <= id_r;
    end
    if (cmd.apply) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply && mode_r == MODE_CLEAR) begin
      count <= '0;
    end else if (do_ins && !full) begin
      count <= count + 1'b1;
    end
  end

  assign status = res;
  assign oldest_id = (count != '0) ? ids[0] : 64'd0;
  assign newest_id = (count != '0) ? newest : 64'd0;
  assign entry_count = 9'(count);
endmodule
`default_nettype wire

// File: rtl/core/rff_ctrl.sv
// sequencing state machine for the replay filter
// depends on rff_pkg
`default_nettype none
module rff_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rff_pkg::stat_t stat,
  output rff_pkg::cmd_t      cmd
);
  import rff_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next = stat.is_clear ? S_ACT : S_RED;
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        cmd.apply = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/received_id_replay_filter.sv
// top level of the received id replay filter
// depends on rff_pkg, rff_ctrl, rff_datapath
//
// one beat in, one beat out. an input beat carries mode (register, look up,
// clear), a 64-bit msg_id and need_ack. the result beat carries status, the
// oldest and newest held ids and the entry count after the step.
// ids sit in a sorted row of 256 shift cells; every cell compares in
// parallel, the hit flags are or-reduced in two levels, the first one
// registered, and the table shifts on insert.
// after accept the controller steps through compare, reduce and apply
// (clear skips reduce) before out_valid; one item is in flight at a time,
// so a new item is taken only after the last result is accepted.
// in_ready is low while an item is in flight and while the result waits;
// a stalled receiver holds the result stable until out_ready.
// reset empties the table at once (count 0); no clearing pass.
`default_nettype none
module received_id_replay_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] msg_id,
  input  wire logic        need_ack,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [63:0]      oldest_id,
  output logic [63:0]      newest_id,
  output logic [8:0]       entry_count
);
  import rff_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rff_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  rff_datapath u_dp (
    .clk, .rst, .cmd, .stat, .mode, .msg_id, .need_ack,
    .status, .oldest_id, .newest_id, .entry_count
  );
endmodule
`default_nettype wire

// File: rtl/core/rff_checker.sv
// port-level checks for the replay filter, bound to the top level
// depends on rff_pkg
`default_nettype none
module rff_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [8:0] entry_count
);
  import rff_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  a_one: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    entry_count <= 9'(TABLE_DEPTH)) else $error("count beyond depth");

  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid && !in_ready) else $error("no work cycle");
endmodule

bind received_id_replay_filter rff_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .entry_count
);
`default_nettype wire
